/* rtl/core/plar_pkg.sv */
// Shared types and constants of the polyline arc-length resampler.
package plar_pkg;

  localparam int COORD_BITS = 12;
  localparam int LEN_BITS = 20;
  localparam int MAX_PER_SEGMENT_DEF = 64;
  localparam logic [LEN_BITS-1:0] TARGET_RESET = LEN_BITS'(256);
  localparam int SEG_BITS = COORD_BITS + 9;
  localparam int SQ_BITS = 2 * COORD_BITS + 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  path_start;
  } point_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic                  last_of_run;
    logic                  overflow;
  } result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  start;
    logic [SQ_BITS-1:0]    sumsq;
  } cmd_t;

endpackage

/* rtl/core/plar_fifo.sv */
// Small register FIFO used between the front, the back and the result side.
module plar_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/plar_front.sv */
// Front end: accepts vertices, classifies path starts, squares the segment deltas.
module plar_front import plar_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  point_t point,
  output logic   full,
  output logic   cmd_push,
  output cmd_t   cmd,
  input  logic   cmd_full
);
  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_SQUARE = 2'd1;
  localparam logic [1:0] ST_PUSH   = 2'd2;

  logic [1:0]            stage;
  logic                  path_open;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic                  cur_start;
  logic [COORD_BITS-1:0] diff_x;
  logic [COORD_BITS-1:0] diff_y;
  logic [2*COORD_BITS-1:0] dxsq;
  logic [2*COORD_BITS-1:0] dysq;
  logic                  accept;

  assign full   = (stage != ST_FREE);
  assign accept = push && !full;

  always_comb begin
    cmd_push  = (stage == ST_PUSH);
    cmd.x     = cur_x;
    cmd.y     = cur_y;
    cmd.start = cur_start;
    cmd.sumsq = SQ_BITS'(dxsq) + SQ_BITS'(dysq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= ST_FREE;
      path_open <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else begin
      unique case (stage)
        ST_FREE: begin
          if (accept) begin
            path_open <= 1'b1;
            prev_x    <= point.point_x;
            prev_y    <= point.point_y;
            stage     <= ST_SQUARE;
          end
        end
        ST_SQUARE: stage <= ST_PUSH;
        ST_PUSH: begin
          if (!cmd_full) stage <= ST_FREE;
        end
        default: stage <= ST_FREE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x     <= point.point_x;
      cur_y     <= point.point_y;
      cur_start <= point.path_start || !path_open;
      diff_x    <= (point.point_x >= prev_x) ? point.point_x - prev_x
                                             : prev_x - point.point_x;
      diff_y    <= (point.point_y >= prev_y) ? point.point_y - prev_y
                                             : prev_y - point.point_y;
    end
    if (stage == ST_SQUARE) begin
      dxsq <= diff_x * diff_x;
      dysq <= diff_y * diff_y;
    end
  end

endmodule

/* rtl/core/plar_back.sv */
// Back end: segment length by iterative square root, cut points by iterative division.
module plar_back import plar_pkg::*; #(
  parameter int MAX_PER_SEGMENT = MAX_PER_SEGMENT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [LEN_BITS-1:0] spacing,
  input  logic                cmd_empty,
  input  cmd_t                cmd,
  output logic                cmd_pop,
  output logic                out_push,
  output result_t             out_data,
  input  logic                out_full
);
  localparam int C   = COORD_BITS;
  localparam int SW  = SEG_BITS;
  localparam int VW  = 2 * C + 18;
  localparam int SQ_STEPS = VW / 2;
  localparam int DIV_STEPS = C + 1;
  localparam int PW  = C + SW;
  localparam int DW  = C + SW + 2;
  localparam int SUMW = SW + 1;
  localparam int NW  = $clog2(MAX_PER_SEGMENT + 1);
  localparam int KW  = $clog2(SQ_STEPS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_LOOP  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;

  logic [2:0]          state;
  logic                axis;
  logic [C-1:0]        prev_x, prev_y, end_x, end_y, p1_x, p1_y;
  logic [C-1:0]        hold_x, hold_y, cut_x;
  logic                hold_valid;
  logic [LEN_BITS-1:0] acc;
  logic [SW-1:0]       seg, rem;
  logic [NW-1:0]       n;
  logic [KW-1:0]       cnt;
  logic [VW-1:0]       sq_v, sq_res, sq_bit;
  logic [PW-1:0]       prod_a, prod_b;
  logic [DW-1:0]       dvd, dsh;
  logic [C:0]          quo;

  logic [VW-1:0]       sq_try, sq_res_next;
  logic                sq_ge;
  logic [SUMW-1:0]     acc_sum;
  logic                due;
  logic [LEN_BITS-1:0] rem0;
  logic [SW-1:0]       rem_calc;
  logic                div_ge;
  logic [C:0]          quo_next;
  logic [C-1:0]        coord;

  always_comb begin
    sq_try      = sq_res + sq_bit;
    sq_ge       = (sq_v >= sq_try);
    sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
    acc_sum     = SUMW'(acc) + SUMW'(seg);
    due         = (acc_sum >= SUMW'(spacing));
    rem0        = (acc < spacing) ? spacing - acc : '0;
    rem_calc    = (SUMW'(rem0) > SUMW'(seg)) ? seg : SW'(rem0);
    div_ge      = (dvd >= dsh);
    quo_next    = {quo[C-1:0], div_ge};
    if (seg == '0) begin
      coord = axis ? p1_y : p1_x;
    end else begin
      coord = quo_next[C] ? {C{1'b1}} : quo_next[C-1:0];
    end
  end

  // Command pop from the command queue and result request toward the output queue.
  always_comb begin
    cmd_pop              = (state == S_IDLE) && !cmd_empty;
    out_push             = 1'b0;
    out_data.out_x       = hold_x;
    out_data.out_y       = hold_y;
    out_data.last_of_run = 1'b1;
    out_data.overflow    = 1'b0;
    unique case (state)
      S_START: begin
        out_push       = 1'b1;
        out_data.out_x = end_x;
        out_data.out_y = end_y;
      end
      S_LOOP: begin
        if (!due) begin
          out_push = hold_valid;
        end else if (n == NW'(MAX_PER_SEGMENT)) begin
          out_push          = 1'b1;
          out_data.overflow = 1'b1;
        end else if (hold_valid) begin
          out_push             = 1'b1;
          out_data.last_of_run = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_x     <= '0;
      prev_y     <= '0;
      acc        <= '0;
      hold_valid <= 1'b0;
      n          <= '0;
      cnt        <= '0;
      axis       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            end_x      <= cmd.x;
            end_y      <= cmd.y;
            p1_x       <= prev_x;
            p1_y       <= prev_y;
            n          <= '0;
            hold_valid <= 1'b0;
            sq_v       <= VW'(cmd.sumsq) << 16;
            sq_res     <= '0;
            sq_bit     <= VW'(1) << (VW - 2);
            cnt        <= '0;
            state      <= cmd.start ? S_START : S_SQRT;
          end
        end
        S_START: begin
          if (!out_full) begin
            prev_x <= end_x;
            prev_y <= end_y;
            acc    <= '0;
            state  <= S_IDLE;
          end
        end
        S_SQRT: begin
          if (sq_ge) sq_v <= sq_v - sq_try;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 1'b1;
          if (cnt == KW'(SQ_STEPS - 1)) begin
            seg   <= sq_res_next[SW-1:0];
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (!due) begin
            if (!hold_valid || !out_full) begin
              acc    <= acc_sum[LEN_BITS-1:0];
              prev_x <= end_x;
              prev_y <= end_y;
              state  <= S_IDLE;
            end
          end else if (n == NW'(MAX_PER_SEGMENT)) begin
            // drop the rest of the segment
            if (!out_full) begin
              acc    <= '0;
              prev_x <= end_x;
              prev_y <= end_y;
              state  <= S_IDLE;
            end
          end else if (hold_valid) begin
            if (!out_full) hold_valid <= 1'b0;
          end else begin
            rem   <= rem_calc;
            axis  <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == KW'(DIV_STEPS - 1)) begin
            if (!axis) begin
              cut_x <= coord;
              axis  <= 1'b1;
              state <= S_MUL;
            end else begin
              hold_x     <= cut_x;
              hold_y     <= coord;
              hold_valid <= 1'b1;
              p1_x       <= cut_x;
              p1_y       <= coord;
              n          <= n + 1'b1;
              seg        <= seg - rem;
              acc        <= '0;
              state      <= S_LOOP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath of the cut: p1*(seg-rem) + end*rem, then (2*num+seg)/(2*seg).
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod_a <= (axis ? p1_y : p1_x) * (seg - rem);
      prod_b <= (axis ? end_y : end_x) * rem;
    end
    if (state == S_ADD) begin
      dvd <= (DW'(prod_a + prod_b) << 1) + DW'(seg);
      dsh <= DW'(seg) << (C + 1);
      quo <= '0;
    end
    if (state == S_DIV) begin
      if (div_ge) dvd <= dvd - dsh;
      dsh <= dsh >> 1;
      quo <= quo_next;
    end
  end

endmodule

/* rtl/core/polyline_arc_length_resampler.sv */
// Polyline arc-length resampler: front end, command queue, back end, result queue.
// A path-start vertex passes the front, the command queue and the back end's start state.
// Each segment runs an iterative square root (one result bit per cycle), then two
// multiply-and-divide passes per emitted point (one quotient bit per cycle). The front
// takes a new vertex only once the last is in a 2-entry queue; the back end sets the rate.
// Synchronous active-high reset clears the path, distance and queues; spacing resets to 256.
module polyline_arc_length_resampler import plar_pkg::*; #(
  parameter int MAX_PER_SEGMENT = MAX_PER_SEGMENT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  point_t              point,
  input  logic                pop,
  output logic                empty,
  output result_t             result,
  input  logic                cfg_write,
  input  logic [LEN_BITS-1:0] cfg_data
);
  logic [LEN_BITS-1:0] spacing;
  logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t                cmd_in, cmd_out;
  logic                out_push, out_full;
  result_t             out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= TARGET_RESET;
    end else if (cfg_write) begin
      spacing <= cfg_data;
    end
  end

  plar_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .point    (point),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  plar_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  plar_back #(.MAX_PER_SEGMENT(MAX_PER_SEGMENT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .spacing   (spacing),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_push  (out_push),
    .out_data  (out_data),
    .out_full  (out_full)
  );

  plar_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_data),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

/* tb/sv/polyline_arc_length_resampler_tb.sv */
// Testbench for the polyline arc-length resampler: directed and random paths, self-checked.
module polyline_arc_length_resampler_tb import plar_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_LIMIT = MAX_PER_SEGMENT_DEF;
  localparam int DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam logic [LEN_BITS-1:0] TARGET_MAX = {LEN_BITS{1'b1}};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  point_t              point = '0;
  logic                pop = 1'b0;
  logic                empty;
  result_t             result;
  logic                cfg_write = 1'b0;
  logic [LEN_BITS-1:0] cfg_data = '0;

  // shadow state of the resampler
  logic [LEN_BITS-1:0]   spacing;
  logic [COORD_BITS-1:0] last_x, last_y;
  logic [LEN_BITS-1:0]   arc_acc;
  logic                  path_live;

  result_t expected_pts[$];
  int      mismatches = 0;
  longint  cycles = 0;
  bit      calm = 1'b0;

  polyline_arc_length_resampler u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .point(point),
    .pop(pop), .empty(empty), .result(result),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [COORD_BITS-1:0] cut_at(input longint p, input longint e,
                                                   input longint rem, input longint seg);
    longint num;
    longint unsigned q;
    if (seg == 0) return p[COORD_BITS-1:0];
    num = p * seg + (e - p) * rem;
    if (num < 0) return '0;
    q = (longint'(num) * 2 + seg) / (seg * 2);
    return (q > {COORD_BITS{1'b1}}) ? {COORD_BITS{1'b1}} : q[COORD_BITS-1:0];
  endfunction

  task automatic resample_vertex(input point_t p);
    longint dx, dy, seg, acc, tgt, rem, sx, sy;
    int n;
    result_t r;
    if (p.path_start || !path_live) begin
      last_x = p.point_x;
      last_y = p.point_y;
      arc_acc = '0;
      path_live = 1'b1;
      r = '{out_x: p.point_x, out_y: p.point_y, last_of_run: 1'b1, overflow: 1'b0};
      expected_pts.insert(expected_pts.size(), r);
      return;
    end
    dx = longint'(p.point_x) - longint'(last_x);
    dy = longint'(p.point_y) - longint'(last_y);
    seg = int_sqrt((dx * dx + dy * dy) << 16);
    acc = arc_acc;
    tgt = spacing;
    sx = last_x;
    sy = last_y;
    n = 0;
    while (acc + seg >= tgt) begin
      if (n == SEG_LIMIT) begin
        expected_pts[expected_pts.size()-1].overflow = 1'b1;
        acc = 0;
        seg = 0;
        break;
      end
      rem = (acc < tgt) ? tgt - acc : 0;
      if (rem > seg) rem = seg;
      r = '0;
      r.out_x = cut_at(sx, p.point_x, rem, seg);
      r.out_y = cut_at(sy, p.point_y, rem, seg);
      expected_pts.insert(expected_pts.size(), r);
      n++;
      sx = r.out_x;
      sy = r.out_y;
      seg -= rem;
      acc = 0;
    end
    arc_acc = LEN_BITS'(acc + seg);
    last_x = p.point_x;
    last_y = p.point_y;
    if (n > 0) expected_pts[expected_pts.size()-1].last_of_run = 1'b1;
  endtask

  // result side: check each accepted result, stall at random
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (expected_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        want = expected_pts.pop_front();
        if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
            result.last_of_run !== want.last_of_run || result.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, result);
        end
      end
    end
    pop <= calm || ($urandom_range(99) >= 17);
  end

  // called right after a rising edge; leaves push high on return
  task automatic send_point(input point_t p);
    if (!calm && $urandom_range(99) < 17) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    point <= p;
    do @(posedge clk); while (full);
    resample_vertex(p);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_spacing(input logic [LEN_BITS-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    spacing = v;
  endtask

  function automatic point_t mk(input int x, input int y, input bit s);
    return '{point_x: COORD_BITS'(x), point_y: COORD_BITS'(y), path_start: s};
  endfunction

  task automatic test_path_basics();
    send_point(mk(10, 20, 0));        // vertex with no open path
    send_point(mk(10, 20, 0));        // zero-length segment
    send_point(mk(10, 20, 1));
    send_point(mk(13, 24, 0));
    send_point(mk(13, 24, 0));
    send_point(mk(0, 0, 1));
    send_point(mk(4095, 4095, 0));    // longest diagonal hits the segment cap
    send_point(mk(4095, 0, 0));
    send_point(mk(0, 4095, 1));
    send_point(mk(0, 4094, 0));
  endtask

  task automatic test_spacing_extremes();
    set_spacing(64);
    send_point(mk(100, 100, 1));
    send_point(mk(103, 104, 0));
    send_point(mk(103, 124, 0));
    set_spacing(TARGET_MAX);
    send_point(mk(0, 0, 1));
    send_point(mk(4095, 4095, 0));
    send_point(mk(0, 0, 0));
    set_spacing(0);
    send_point(mk(50, 60, 1));
    send_point(mk(51, 60, 0));
  endtask

  task automatic test_spacing_lowered();
    set_spacing(20 * 256);
    send_point(mk(200, 200, 1));
    send_point(mk(210, 200, 0));
    set_spacing(256);                 // accumulated distance now above spacing
    send_point(mk(212, 200, 0));
    send_point(mk(212, 203, 0));
  endtask

  task automatic test_drain_pause();
    send_point(mk(300, 300, 1));
    drain();
    send_point(mk(305, 310, 0));
    drain();
    send_point(mk(305, 311, 0));
  endtask

  task automatic random_phase(input int items);
    int x, y, k;
    k = 0;
    x = $urandom_range(4095);
    y = $urandom_range(4095);
    while (k < items) begin
      case ($urandom_range(9))
        0: send_point(mk($urandom_range(4095), $urandom_range(4095), 1'($urandom_range(1))));
        1: begin
          x = $urandom_range(4095);
          y = $urandom_range(4095);
          send_point(mk(x, y, 1));
        end
        default: begin
          x = x + $urandom_range(40) - 20;
          y = y + $urandom_range(40) - 20;
          x = (x < 0) ? 0 : (x > 4095 ? 4095 : x);
          y = (y < 0) ? 0 : (y > 4095 ? 4095 : y);
          send_point(mk(x, y, 0));
        end
      endcase
      k++;
    end
  endtask

  task automatic test_random();
    int lens[6];
    lens = '{256, 64, 1000, 3 * 256, 8 * 256, 0};
    for (int i = 0; i < 6; i++) begin
      set_spacing(lens[i] == 1000 ? LEN_BITS'($urandom_range(64, 4096)) : LEN_BITS'(lens[i]));
      calm = (i == 2);
      random_phase(i == 5 ? 20 : 90);
    end
    calm = 1'b0;
    set_spacing(TARGET_MAX);
    random_phase(20);
  endtask

  initial begin
    spacing = TARGET_RESET;
    last_x = '0;
    last_y = '0;
    arc_acc = '0;
    path_live = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_path_basics();
    test_spacing_extremes();
    test_spacing_lowered();
    test_drain_pause();
    test_random();
    drain();
    if (mismatches == 0 && expected_pts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
